### rtl/hsqp_pkg.sv
// ----------------------------------------------------------------------------
// hsqp_pkg
// shared sizes, codes and queue entry type of the quadratic-probe hash set
// ----------------------------------------------------------------------------
package hsqp_pkg;

	localparam int TABLE_SIZE    = 128;
	localparam int MAX_KEY_CHARS = 8;
	localparam int KEY_W         = 64;
	localparam int CHAR_W        = 8;
	localparam int NUM_CHARS     = KEY_W / CHAR_W;
	localparam int CHAR_IDX_W    = $clog2(NUM_CHARS);
	localparam int IDX_W         = $clog2(TABLE_SIZE);
	localparam int CNT_W         = $clog2(TABLE_SIZE + 1);
	localparam int LOAD_W        = 7;
	localparam int STATUS_W      = 3;
	localparam int HASH_SEED     = 131;
	localparam int PCT_FULL      = 100;
	localparam int LIM_W         = $clog2(TABLE_SIZE * (2 ** LOAD_W));
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LOAD_W-1:0] LOAD_RESET = LOAD_W'(75);

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_FIND   = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_STORED  = 3'd0,
		ST_ALREADY = 3'd1,
		ST_REFUSED = 3'd2,
		ST_LIMIT   = 3'd3,
		ST_LOOKUP  = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [KEY_W-1:0]  key;
		logic [IDX_W-1:0]  home;
	} qent_t;

endpackage

### rtl/hsqp_intf.sv
// ----------------------------------------------------------------------------
// hsqp channel interfaces
// request, response and configuration write channels with valid/ready
// ----------------------------------------------------------------------------
interface hsqp_req_if import hsqp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [KEY_W-1:0]  key_chars;

	modport source (output valid, output command, output key_chars, input ready);
	modport sink   (input valid, input command, input key_chars, output ready);
endinterface

interface hsqp_rsp_if import hsqp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 present;
	logic [STATUS_W-1:0]  status;
	logic [IDX_W-1:0]     slot_index;
	logic [CNT_W-1:0]     fill_count;

	modport source (output valid, output present, output status, output slot_index,
		output fill_count, input ready);
	modport sink   (input valid, input present, input status, input slot_index,
		input fill_count, output ready);
endinterface

interface hsqp_cfg_if import hsqp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LOAD_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/hsqp_front.sv
// ----------------------------------------------------------------------------
// hsqp_front
// accepts a request beat, trims the key and hashes it one character a cycle
// ----------------------------------------------------------------------------
module hsqp_front
	import hsqp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	hsqp_req_if.sink     req,
	output logic         push_valid,
	input  logic         push_ready,
	output qent_t        push_data
);

	typedef enum logic [1:0] {
		IDLE,
		HASH,
		PUSH
	} state_t;

	state_t                 state_q;
	logic [CHAR_IDX_W-1:0]  char_q;
	logic                   ended_q;
	logic [KEY_W-1:0]       raw_q;
	logic [KEY_W-1:0]       key_q;
	logic [IDX_W-1:0]       hash_q;
	cmd_t                   cmd_q;

	logic [CHAR_W-1:0]      cur_char;
	logic                   ended_now;
	logic [CHAR_W-1:0]      use_char;

	assign cur_char  = raw_q[KEY_W-1 -: CHAR_W];
	assign ended_now = ended_q || (cur_char == '0) || (32'(char_q) >= MAX_KEY_CHARS);
	assign use_char  = ended_now ? '0 : cur_char;

	assign req.ready      = (state_q == IDLE);
	assign push_valid     = (state_q == PUSH);
	assign push_data.cmd  = cmd_q;
	assign push_data.key  = key_q;
	assign push_data.home = hash_q;

	// low bits of the wrapped hash give the slot, the table size being a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			char_q  <= '0;
			ended_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (req.valid) begin
						raw_q   <= req.key_chars;
						cmd_q   <= cmd_t'(req.command);
						key_q   <= '0;
						hash_q  <= '0;
						char_q  <= '0;
						ended_q <= 1'b0;
						state_q <= HASH;
					end
				end
				HASH: begin
					// characters after the end byte leave the hash alone
					if (!ended_now) begin
						hash_q <= IDX_W'(32'(hash_q) * HASH_SEED + 32'(use_char));
					end
					key_q   <= {key_q[KEY_W-CHAR_W-1:0], use_char};
					raw_q   <= raw_q << CHAR_W;
					ended_q <= ended_now;
					char_q  <= char_q + 1'b1;
					if (char_q == CHAR_IDX_W'(NUM_CHARS - 1)) begin
						state_q <= PUSH;
					end
				end
				PUSH: begin
					if (push_ready) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

### rtl/hsqp_queue.sv
// ----------------------------------------------------------------------------
// hsqp_queue
// short fifo of hashed requests between front and back
// ----------------------------------------------------------------------------
module hsqp_queue
	import hsqp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  qent_t  push_data,
	output logic   pop_valid,
	input  logic   pop_ready,
	output qent_t  pop_data
);

	qent_t               ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = ent_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/hsqp_back.sv
// ----------------------------------------------------------------------------
// hsqp_back
// probes the slot memory, applies insert or find, and holds the response
// ----------------------------------------------------------------------------
module hsqp_back
	import hsqp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  qent_t              pop_data,
	input  logic [LOAD_W-1:0]  load_percent,
	hsqp_rsp_if.source         rsp
);

	typedef enum logic [1:0] {
		IDLE,
		READ,
		CMP,
		FIN
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	logic [KEY_W-1:0]     key_q;
	logic [IDX_W-1:0]     ind_q;
	logic [IDX_W-1:0]     t_q;
	logic [IDX_W-1:0]     sq_q;
	logic [IDX_W-1:0]     steps_q;
	logic                 stop_q;
	logic                 hit_q;
	logic [CNT_W-1:0]     occ_q;
	logic [TABLE_SIZE-1:0] slot_valid_q;

	logic [KEY_W-1:0]     slot_keys [TABLE_SIZE];
	logic [KEY_W-1:0]     rd_key_q;
	logic                 rd_vld_q;

	logic                 rsp_valid_q;
	logic                 rsp_present_q;
	status_t              rsp_status_q;
	logic [IDX_W-1:0]     rsp_slot_q;
	logic [CNT_W-1:0]     rsp_fill_q;

	logic                 out_free;
	logic                 slot_stop;
	logic [LIM_W-1:0]     need_w;
	logic [LIM_W-1:0]     cap_w;
	logic                 over;
	logic                 wr_en;

	assign pop_ready = (state_q == IDLE);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign slot_stop = !rd_vld_q || (rd_key_q == key_q);

	// (fill + 1) * 100 against table size * percent
	assign need_w = (LIM_W'(occ_q) + LIM_W'(1)) * LIM_W'(PCT_FULL);
	assign cap_w  = LIM_W'(load_percent) * LIM_W'(TABLE_SIZE);
	assign over   = need_w > cap_w;

	assign wr_en = (state_q == FIN) && out_free && stop_q && (cmd_q == CMD_INSERT)
		&& !hit_q && !over;

	assign rsp.valid      = rsp_valid_q;
	assign rsp.present    = rsp_present_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.slot_index = rsp_slot_q;
	assign rsp.fill_count = rsp_fill_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_keys[ind_q] <= key_q;
		end
		rd_key_q <= slot_keys[ind_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			occ_q        <= '0;
			slot_valid_q <= '0;
			rd_vld_q     <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			rd_vld_q <= slot_valid_q[ind_q];
			if ((state_q == FIN) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (pop_valid) begin
						cmd_q   <= pop_data.cmd;
						key_q   <= pop_data.key;
						ind_q   <= pop_data.home;
						t_q     <= IDX_W'(1);
						sq_q    <= IDX_W'(1);
						steps_q <= '0;
						state_q <= READ;
					end
				end
				READ: begin
					state_q <= CMP;
				end
				CMP: begin
					if (slot_stop) begin
						stop_q  <= 1'b1;
						hit_q   <= rd_vld_q;
						state_q <= FIN;
					end else if (steps_q == IDX_W'(TABLE_SIZE - 1)) begin
						// bound reached, ind stays on the last slot examined
						stop_q  <= 1'b0;
						hit_q   <= 1'b0;
						state_q <= FIN;
					end else begin
						// next square from the last: (t+1)^2 = t^2 + 2t + 1
						ind_q   <= ind_q + sq_q;
						sq_q    <= sq_q + {t_q[IDX_W-2:0], 1'b1};
						t_q     <= t_q + 1'b1;
						steps_q <= steps_q + 1'b1;
						state_q <= READ;
					end
				end
				FIN: begin
					if (out_free) begin
						rsp_slot_q  <= ind_q;
						state_q     <= IDLE;
						if (!stop_q) begin
							rsp_present_q <= 1'b0;
							rsp_status_q  <= ST_LIMIT;
							rsp_fill_q    <= occ_q;
						end else if (cmd_q == CMD_FIND) begin
							rsp_present_q <= hit_q;
							rsp_status_q  <= ST_LOOKUP;
							rsp_fill_q    <= occ_q;
						end else if (hit_q) begin
							rsp_present_q <= 1'b1;
							rsp_status_q  <= ST_ALREADY;
							rsp_fill_q    <= occ_q;
						end else if (over) begin
							rsp_present_q <= 1'b0;
							rsp_status_q  <= ST_REFUSED;
							rsp_fill_q    <= occ_q;
						end else begin
							rsp_present_q       <= 1'b1;
							rsp_status_q        <= ST_STORED;
							rsp_fill_q          <= occ_q + 1'b1;
							occ_q               <= occ_q + 1'b1;
							slot_valid_q[ind_q] <= 1'b1;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= TABLE_SIZE)
		else $error("fill count above table size");

	a_stored_present: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_status_q == ST_STORED) |-> rsp_present_q)
		else $error("stored key not reported present");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !slot_valid_q[ind_q])
		else $error("insert into an occupied slot");

	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == READ) |=> (state_q == CMP))
		else $error("compare did not follow slot read");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (occ_q == $past(occ_q) + 1'b1))
		else $error("fill count not advanced on insert");

endmodule

### rtl/hash_set_quadratic_probe.sv
// ----------------------------------------------------------------------------
// hash_set_quadratic_probe
// open-addressing hash set of 64-bit keys with quadratic probing
// ----------------------------------------------------------------------------
// A request beat carries insert or find and a key of up to eight bytes; one
// response beat comes back per request, in order. The front takes a beat,
// hashes the key one character a cycle and hands it off into a two-entry
// queue. The back pops the queue and walks the probe sequence through the
// single-port slot memory, reading and then comparing each slot examined,
// up to 128 slots, and finishes once the response register is free. The
// slower side sets the sustained rate: the front while probes are short,
// the probe loop once they grow long; each side works on its own request
// while the other runs. Slot valid bits clear at reset, so no clearing pass
// is needed. The user must write the load limit on the cfg channel only
// while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module hash_set_quadratic_probe
	import hsqp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	hsqp_req_if.sink   req,
	hsqp_rsp_if.source rsp,
	hsqp_cfg_if.sink   cfg
);

	logic [LOAD_W-1:0] load_percent_q;
	logic              push_valid;
	logic              push_ready;
	qent_t             push_data;
	logic              pop_valid;
	logic              pop_ready;
	qent_t             pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_percent_q <= LOAD_RESET;
		end else if (cfg.valid) begin
			load_percent_q <= cfg.data;
		end
	end

	hsqp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	hsqp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	hsqp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.load_percent (load_percent_q),
		.rsp          (rsp)
	);

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench for hash_set_quadratic_probe
// Drives insert and find requests and checks every response against an
// in-bench copy of the table. The run starts with hand-picked keys: the
// empty key, full-width keys, bytes after the end marker, and home-slot
// collisions. Random phases follow under load limits from 0 up to 127, and
// the table fills until refusals and the probe bound show up. Both channels
// idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module testbench;
	import hsqp_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int PHASE_SETTLE = 4;
	localparam int NUM_PHASES   = 7;

	typedef struct {
		cmd_t              cmd;
		logic [KEY_W-1:0]  key;
	} hs_request_t;

	typedef struct packed {
		logic              present;
		status_t           status;
		logic [IDX_W-1:0]  slot;
		logic [CNT_W-1:0]  fill;
	} hs_result_t;

	logic clk = 1'b0;
	logic arst_n;

	hsqp_req_if req_ch ();
	hsqp_rsp_if rsp_ch ();
	hsqp_cfg_if cfg_ch ();

	hash_set_quadratic_probe dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// bench copy of the table
	logic [KEY_W-1:0]   slot_key  [TABLE_SIZE];
	bit                 slot_used [TABLE_SIZE];
	int unsigned        fill_now = 0;
	logic [LOAD_W-1:0]  load_pct = LOAD_RESET;

	hs_request_t        pending_reqs [$];
	hs_result_t         expected_rsps [$];
	logic [KEY_W-1:0]   key_pool [$];
	hs_request_t        next_req;
	hs_result_t         want;

	int phase_load  [NUM_PHASES] = '{0, 1, 25, 50, 75, 100, 127};
	int phase_items [NUM_PHASES] = '{80, 80, 400, 400, 400, 300, 250};

	bit idling = 1'b1;
	bit req_took;
	int req_gap;
	int rsp_stall;
	int queued_reqs;
	int rsp_beats;
	int mismatches;
	int cycle_count;
	int find_hits;
	int status_tally [8];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// trims the key, hashes it, walks the probe sequence and applies the command
	function automatic hs_result_t apply_request(input cmd_t cmd, input logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0]   key;
		logic [31:0]        h;
		logic [CHAR_W-1:0]  ch;
		int unsigned        ind;
		int unsigned        t;
		bit                 ended;
		bit                 stopped;
		hs_result_t         res;
		key = '0;
		h = '0;
		ended = 1'b0;
		for (int i = 0; i < MAX_KEY_CHARS; i++) begin
			ch = raw[KEY_W-1-CHAR_W*i -: CHAR_W];
			if (ch == '0)
				ended = 1'b1;
			if (!ended) begin
				key[KEY_W-1-CHAR_W*i -: CHAR_W] = ch;
				h = h * 32'(HASH_SEED) + 32'(ch);
			end
		end
		ind = (h & 32'h7fff_ffff) % TABLE_SIZE;
		t = 1;
		stopped = 1'b0;
		for (int steps = 0; steps < TABLE_SIZE && !stopped; steps++) begin
			if (!slot_used[ind] || slot_key[ind] == key)
				stopped = 1'b1;
			else if (steps + 1 < TABLE_SIZE) begin
				ind = (ind + t * t) % TABLE_SIZE;
				t++;
			end
		end
		res.present = 1'b0;
		if (!stopped) begin
			res.status = ST_LIMIT;
		end else if (cmd == CMD_FIND) begin
			res.present = slot_used[ind];
			res.status = ST_LOOKUP;
		end else if (slot_used[ind]) begin
			res.present = 1'b1;
			res.status = ST_ALREADY;
		end else if ((fill_now + 1) * PCT_FULL > TABLE_SIZE * load_pct) begin
			res.status = ST_REFUSED;
		end else begin
			slot_key[ind] = key;
			slot_used[ind] = 1'b1;
			fill_now++;
			res.present = 1'b1;
			res.status = ST_STORED;
		end
		res.slot = IDX_W'(ind);
		res.fill = CNT_W'(fill_now);
		return res;
	endfunction

	// random bytes after the end marker, which the block must ignore
	function automatic logic [KEY_W-1:0] scramble_tail(input logic [KEY_W-1:0] raw);
		bit ended;
		ended = 1'b0;
		for (int i = 0; i < NUM_CHARS; i++) begin
			if (ended && $urandom_range(0, 1) == 1)
				raw[KEY_W-1-CHAR_W*i -: CHAR_W] = CHAR_W'($urandom_range(0, 255));
			else if (raw[KEY_W-1-CHAR_W*i -: CHAR_W] == '0)
				ended = 1'b1;
		end
		return raw;
	endfunction

	task automatic queue_req(input cmd_t cmd, input logic [KEY_W-1:0] key);
		pending_reqs.push_back('{cmd, key});
		key_pool.push_back(key);
		queued_reqs++;
	endtask

	// mix of fresh keys (mostly inserts), reused keys and raw noise
	task automatic queue_random(input int count);
		logic [KEY_W-1:0] raw;
		int pick;
		int len;
		cmd_t cmd;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				raw = {$urandom, $urandom};
				cmd = cmd_t'($urandom_range(0, 1));
			end else if (pick < 5) begin
				raw = scramble_tail(key_pool[$urandom_range(0, key_pool.size() - 1)]);
				cmd = cmd_t'($urandom_range(0, 1));
			end else begin
				len = $urandom_range(0, 12);
				raw = '0;
				for (int i = 0; i < NUM_CHARS; i++)
					if (i < len)
						raw[KEY_W-1-CHAR_W*i -: CHAR_W] = CHAR_W'($urandom_range(1, 255));
				raw = scramble_tail(raw);
				cmd = ($urandom_range(0, 9) < 7) ? CMD_INSERT : CMD_FIND;
			end
			queue_req(cmd, raw);
		end
	endtask

	task automatic settle;
		while (rsp_beats < queued_reqs)
			@(negedge clk);
		repeat (PHASE_SETTLE) @(negedge clk);
	endtask

	task automatic write_load(input logic [LOAD_W-1:0] pct);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= pct;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		load_pct = pct;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_took) begin
			if (req_gap != 0) begin
				req_gap--;
				req_ch.valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				next_req = pending_reqs.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.command <= next_req.cmd;
				req_ch.key_chars <= next_req.key;
				if (idling && $urandom_range(0, 9) == 0)
					req_gap = $urandom_range(1, 8);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// response back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (rsp_stall != 0) begin
			rsp_stall--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (idling && $urandom_range(0, 7) == 0)
				rsp_stall = $urandom_range(1, 8);
		end
	end

	// monitor: predict on each request beat, check each response beat
	always @(posedge clk) begin
		req_took <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && req_ch.valid && req_ch.ready)
			expected_rsps.push_back(apply_request(cmd_t'(req_ch.command), req_ch.key_chars));
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			rsp_beats++;
			if (expected_rsps.size() == 0) begin
				$display("%0t: response beat with nothing expected (status %0d slot %0d)",
					$time, rsp_ch.status, rsp_ch.slot_index);
				mismatches++;
			end else begin
				want = expected_rsps.pop_front();
				status_tally[want.status]++;
				if (want.status == ST_LOOKUP && want.present)
					find_hits++;
				if (rsp_ch.present !== want.present) begin
					$display("%0t: present expected %0b got %0b", $time, want.present,
						rsp_ch.present);
					mismatches++;
				end
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status,
						rsp_ch.status);
					mismatches++;
				end
				if (rsp_ch.slot_index !== want.slot) begin
					$display("%0t: slot_index expected %0d got %0d", $time, want.slot,
						rsp_ch.slot_index);
					mismatches++;
				end
				if (rsp_ch.fill_count !== want.fill) begin
					$display("%0t: fill_count expected %0d got %0d", $time, want.fill,
						rsp_ch.fill_count);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timed out after %0d cycles, %0d of %0d responses seen", $time,
				cycle_count, rsp_beats, queued_reqs);
			$display("** hash_set_quadratic_probe: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = 1'b0;
		req_ch.key_chars = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// hand-picked keys under the reset load limit
		queue_req(CMD_FIND,   64'h0000_0000_0000_0000);
		queue_req(CMD_INSERT, 64'h0000_0000_0000_0000);
		queue_req(CMD_INSERT, 64'h00FF_FFFF_FFFF_FFFF);
		queue_req(CMD_FIND,   64'h0011_2233_4455_6677);
		queue_req(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_req(CMD_FIND,   64'hFFFF_FFFF_FFFF_FFFF);
		queue_req(CMD_INSERT, 64'h0101_0101_0101_0101);
		queue_req(CMD_INSERT, 64'h4100_0000_0000_0000);
		queue_req(CMD_INSERT, 64'h4100_FFFF_0000_1234);
		// home slot 0, already taken by the empty key
		queue_req(CMD_INSERT, 64'h8000_0000_0000_0000);
		queue_req(CMD_FIND,   64'h8000_CDEF_0123_4567);
		// three keys sharing home slot 1
		queue_req(CMD_INSERT, 64'h0100_0000_0000_0000);
		queue_req(CMD_INSERT, 64'h8100_0000_0000_0000);
		queue_req(CMD_INSERT, 64'h017E_0000_0000_0000);
		queue_req(CMD_FIND,   64'h017E_00AA_0000_0000);
		queue_req(CMD_FIND,   64'h017F_0000_0000_0000);
		queue_req(CMD_INSERT, 64'h55AA_55AA_55AA_55AA);
		queue_req(CMD_INSERT, 64'hAA55_AA55_AA55_AA55);
		queue_req(CMD_FIND,   64'hAA55_AA55_AA55_AA55);
		queue_req(CMD_INSERT, 64'h4142_0043_4445_4647);
		queue_req(CMD_FIND,   64'h4142_0000_0000_0000);
		queue_req(CMD_FIND,   64'h7FFF_FFFF_FFFF_FFFE);
		settle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_load(LOAD_W'(phase_load[p]));
			idling = (p != NUM_PHASES - 1);
			queue_random(phase_items[p]);
			settle();
		end

		if (expected_rsps.size() != 0) begin
			$display("%0t: %0d expected responses never arrived", $time, expected_rsps.size());
			mismatches++;
		end
		$display("%0d requests under load limits 75, 0, 1, 25, 50, 75, 100, 127; final fill %0d of %0d",
			queued_reqs, fill_now, TABLE_SIZE);
		$display("%0d stored, %0d duplicates, %0d refused, %0d probe bound, %0d finds (%0d hits)",
			status_tally[ST_STORED], status_tally[ST_ALREADY], status_tally[ST_REFUSED],
			status_tally[ST_LIMIT], status_tally[ST_LOOKUP], find_hits);
		if (mismatches == 0)
			$display("** hash_set_quadratic_probe: PASSED **");
		else
			$display("** hash_set_quadratic_probe: FAILED **");
		$finish;
	end

endmodule
